// ===== rtl/adc_moving_average_fan_duty_defines.svh =====
// Assertion macros shared by the fan duty block.
// Each macro wraps one concurrent property on a clock with a reset that disables it.
`ifndef ADC_MOVING_AVERAGE_FAN_DUTY_DEFINES_SVH
`define ADC_MOVING_AVERAGE_FAN_DUTY_DEFINES_SVH

// Property that must hold at every sampled edge out of reset.
`define AMAFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AMAFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/amafd_pkg.sv =====
// Types and constants of the moving average fan duty block.
// No dependencies; used by the controller, divider, datapath and top level.
`timescale 1ns / 1ps

package amafd_pkg;

   localparam logic [14:0] TARGET_RESET = 15'd2000;
   // Full scale of 318 degrees over 4096 counts, expressed in hundredths of a degree.
   localparam logic [14:0] TEMP_SCALE   = 15'd31800;
   localparam int          ADC_SHIFT    = 12;
   localparam logic [6:0]  DUTY_GAIN    = 7'd100;
   localparam logic [6:0]  DUTY_MAX     = 7'd100;
   localparam logic [3:0]  PWM_STEP     = 4'd10;

   // The divider produces the 7-bit duty quotient, one bit per step.
   localparam logic [3:0]  DUTY_STEPS   = 4'd7;

   localparam logic [1:0]  DUTY_SEL_ZERO = 2'd0;
   localparam logic [1:0]  DUTY_SEL_MAX  = 2'd1;
   localparam logic [1:0]  DUTY_SEL_QUOT = 2'd2;

   typedef struct packed {
      logic       req_ready;
      logic       update;
      logic       div_start;
      logic       avg_latch;
      logic       diff_calc;
      logic       duty_load;
      logic [1:0] duty_sel;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic div_done;
      logic out_blocked;
      logic avg_gt;
      logic duty_clamp;
   } dp_status_type;

endpackage

// ===== rtl/amafd_if.sv =====
// Valid/ready channel interfaces for sample requests and duty results.
// Field widths follow the fixed widths in amafd_pkg.
`timescale 1ns / 1ps

interface amafd_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface amafd_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] average_temperature;
   logic [6:0]  duty_percent;
   logic [9:0]  pwm_compare;

   modport source (output valid, output average_temperature, output duty_percent,
                   output pwm_compare, input ready);
   modport sink   (input valid, input average_temperature, input duty_percent,
                   input pwm_compare, output ready);
endinterface

// ===== rtl/amafd_ctrl.sv =====
// Sequencing state machine of the fan duty block.
// Depends on amafd_pkg for command and status structs and on the assertion macros.
`timescale 1ns / 1ps
`include "adc_moving_average_fan_duty_defines.svh"

module amafd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  amafd_pkg::dp_status_type st,
   output amafd_pkg::ctrl_cmd_type  cmd
);
   import amafd_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UPD      = 4'd1;
   localparam logic [3:0] S_AVG      = 4'd2;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_DECIDE   = 4'd6;
   localparam logic [3:0] S_DUTY_RUN = 4'd7;
   localparam logic [3:0] S_DUTY_LAT = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (st.req_valid) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_AVG;
         end
         S_AVG: begin
            cmd.avg_latch = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.diff_calc = 1'b1;
            state_in      = S_DECIDE;
         end
         S_DECIDE: begin
            if (!st.avg_gt) begin
               cmd.duty_load = 1'b1;
               cmd.duty_sel  = DUTY_SEL_ZERO;
               state_in      = S_FINISH;
            end else if (st.duty_clamp) begin
               cmd.duty_load = 1'b1;
               cmd.duty_sel  = DUTY_SEL_MAX;
               state_in      = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DUTY_RUN;
            end
         end
         S_DUTY_RUN: begin
            if (st.div_done) begin
               state_in = S_DUTY_LAT;
            end
         end
         S_DUTY_LAT: begin
            cmd.duty_load = 1'b1;
            cmd.duty_sel  = DUTY_SEL_QUOT;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // Hold the result until the output register can take it.
            if (!st.out_blocked) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `AMAFD_ASSERT_NEXT(a_accept_to_update, clock, reset, cmd.req_ready && st.req_valid,
                      state_ff == S_UPD, "accepted request did not start the ring update")
   `AMAFD_ASSERT(a_done_in_run, clock, reset,
                 !st.div_done || state_ff == S_DUTY_RUN,
                 "divider finished outside the divide state")
   `AMAFD_ASSERT(a_no_load_blocked, clock, reset, !(cmd.out_load && st.out_blocked),
                 "result loaded over one not yet taken")

endmodule

// ===== rtl/amafd_div.sv =====
// Restoring divider for the duty quotient, one quotient bit per cycle.
// Depends on amafd_pkg for the step count.
`timescale 1ns / 1ps

module amafd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [14:0] rem_init,
   input  logic [14:0] shift_init,
   input  logic [14:0] divisor,
   output logic        done,
   output logic [14:0] quotient
);
   import amafd_pkg::*;

   logic        busy_ff;
   logic [3:0]  cnt_ff;
   logic [14:0] rem_ff;
   logic [14:0] shift_ff;
   logic [14:0] divisor_ff;

   logic [15:0] rem_sh;
   logic        fits;
   logic [15:0] rem_diff;

   // The caller supplies the dividend with the bits that give zero quotient
   // bits already moved into the partial remainder.
   assign rem_sh   = {rem_ff, shift_ff[14]};
   assign rem_diff = rem_sh - {1'b0, divisor_ff};
   assign fits     = rem_sh >= {1'b0, divisor_ff};

   assign done     = busy_ff && (cnt_ff == 4'd1);
   assign quotient = shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DUTY_STEPS;
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != 4'd1);
         cnt_ff  <= cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= rem_init;
         shift_ff   <= shift_init;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff   <= fits ? rem_diff[14:0] : rem_sh[14:0];
         shift_ff <= {shift_ff[13:0], fits};
      end
   end

endmodule

// ===== rtl/amafd_dp.sv =====
// Datapath: conversion, ring buffer with running sum, duty arithmetic, result register.
// Depends on amafd_pkg, amafd_if, amafd_div and the assertion macros.
`timescale 1ns / 1ps
`include "adc_moving_average_fan_duty_defines.svh"

module amafd_dp #(
   parameter int WINDOW_LENGTH = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   amafd_req_if.sink                req_chan,
   amafd_rsp_if.source              rsp_chan,
   input  logic                     csr_write_enable,
   input  logic [14:0]              csr_write_data,
   input  amafd_pkg::ctrl_cmd_type  cmd,
   output amafd_pkg::dp_status_type st
);
   import amafd_pkg::*;

   localparam int CLOG_W      = $clog2(WINDOW_LENGTH);
   localparam int IDX_W       = (WINDOW_LENGTH > 1) ? CLOG_W : 1;
   localparam int SUM_W       = 15 + CLOG_W;
   // The average is (sum * RECIP) >> RECIP_SHIFT, which equals the truncated
   // quotient by the window length for every sum below 2**SUM_W.
   localparam int RECIP_SHIFT = SUM_W + CLOG_W;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int AVG_PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(WINDOW_LENGTH) + 64'd1);

   logic [14:0]              target_ff;
   logic [14:0]              ring_mem [WINDOW_LENGTH];
   logic [WINDOW_LENGTH-1:0] ring_valid_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [14:0]              temp_ff;
   logic [14:0]              old_ff;
   logic                     old_valid_ff;
   logic [14:0]              avg_ff;
   logic                     avg_gt_ff;
   logic [21:0]              prod_ff;
   logic [6:0]               duty_ff;
   logic                     rsp_valid_ff;
   logic [14:0]              rsp_avg_ff;
   logic [6:0]               rsp_duty_ff;
   logic [9:0]               rsp_pwm_ff;

   logic                     accept;
   logic [26:0]              temp_prod;
   logic [14:0]              old_entry;
   logic [SUM_W-1:0]         sum_in;
   logic [AVG_PROD_W-1:0]    avg_prod;
   logic [14:0]              diff_c;
   logic [21:0]              prod_c;
   logic [14:0]              div_rem_init;
   logic [14:0]              div_shift_init;
   logic [14:0]              div_divisor;
   logic                     div_done;
   logic [14:0]              div_quot;
   logic [6:0]               duty_quot;
   logic [9:0]               pwm_c;

   assign accept         = req_chan.valid && cmd.req_ready;
   assign req_chan.ready = cmd.req_ready;

   assign temp_prod = 27'(req_chan.adc_sample) * 27'(TEMP_SCALE);
   assign old_entry = old_valid_ff ? old_ff : 15'd0;
   assign sum_in    = sum_ff - SUM_W'(old_entry) + SUM_W'(temp_ff);
   assign avg_prod  = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(RECIP);
   assign diff_c    = avg_ff - target_ff;
   assign prod_c    = 22'(diff_c) * 22'(DUTY_GAIN);

   // A duty quotient reaching 128 is clamped before the divider starts.
   assign div_rem_init   = prod_ff[21:7];
   assign div_shift_init = {prod_ff[6:0], 8'd0};
   assign div_divisor    = target_ff;

   amafd_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .rem_init   (div_rem_init),
      .shift_init (div_shift_init),
      .divisor    (div_divisor),
      .done       (div_done),
      .quotient   (div_quot)
   );

   assign duty_quot = (div_quot[6:0] > DUTY_MAX) ? DUTY_MAX : div_quot[6:0];
   assign pwm_c     = 10'(duty_ff) * 10'(PWM_STEP);

   assign st.req_valid   = req_chan.valid;
   assign st.div_done    = div_done;
   assign st.out_blocked = rsp_valid_ff && !rsp_chan.ready;
   assign st.avg_gt      = avg_gt_ff;
   assign st.duty_clamp  = prod_ff[21:7] >= target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= TARGET_RESET;
         ring_valid_ff <= '0;
         idx_ff        <= '0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            target_ff <= csr_write_data;
         end
         if (cmd.update) begin
            ring_valid_ff[idx_ff] <= 1'b1;
            sum_ff                <= sum_in;
            idx_ff                <= (idx_ff == IDX_W'(WINDOW_LENGTH - 1)) ?
                                     '0 : idx_ff + IDX_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[idx_ff] <= temp_ff;
      end
      if (accept) begin
         old_ff <= ring_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         temp_ff      <= temp_prod[26:ADC_SHIFT];
         old_valid_ff <= ring_valid_ff[idx_ff];
      end
      if (cmd.avg_latch) begin
         avg_ff <= avg_prod[RECIP_SHIFT +: 15];
      end
      if (cmd.diff_calc) begin
         avg_gt_ff <= avg_ff > target_ff;
         prod_ff   <= prod_c;
      end
      if (cmd.duty_load) begin
         case (cmd.duty_sel)
            DUTY_SEL_ZERO: duty_ff <= 7'd0;
            DUTY_SEL_MAX:  duty_ff <= DUTY_MAX;
            DUTY_SEL_QUOT: duty_ff <= duty_quot;
            default:       duty_ff <= 7'd0;
         endcase
      end
      if (cmd.out_load) begin
         rsp_avg_ff  <= avg_ff;
         rsp_duty_ff <= duty_ff;
         rsp_pwm_ff  <= pwm_c;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.average_temperature = rsp_avg_ff;
   assign rsp_chan.duty_percent        = rsp_duty_ff;
   assign rsp_chan.pwm_compare         = rsp_pwm_ff;

   `AMAFD_ASSERT_NEXT(a_duty_bounded, clock, reset, cmd.duty_load, duty_ff <= DUTY_MAX,
                      "duty above the clamp limit")
   `AMAFD_ASSERT_NEXT(a_cool_zero_duty, clock, reset, cmd.duty_load && !avg_gt_ff,
                      duty_ff == 7'd0, "nonzero duty with average at or below target")
   `AMAFD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_chan.ready,
                      rsp_valid_ff && $stable(rsp_avg_ff) && $stable(rsp_duty_ff),
                      "waiting result changed before it was taken")

endmodule

// ===== rtl/adc_moving_average_fan_duty.sv =====
// Top level of the moving average fan duty block.
// Depends on amafd_pkg, amafd_if, amafd_ctrl and amafd_dp.
//
//   Channel     Direction  Handshake       Payload
//   req_chan    in         valid/ready     adc_sample[11:0]
//   rsp_chan    out        valid/ready     average_temperature[14:0], duty_percent[6:0],
//                                          pwm_compare[9:0]
//   csr_*       in         write enable    target_temperature[14:0]
//
// Requests are taken one at a time: an accepted request passes the update, average,
// multiply and decide states to the finish state when the duty is zero or clamped, and
// also the 7 steps of the one-bit-per-cycle duty divider and its latch when the duty
// quotient is divided out. The average comes from a combinational reciprocal multiply.
// The result register lets a new request enter while the last result waits; a stalled
// result holds the sequencer before it loads the next one. Reset is synchronous: it clears
// the ring valid bits, running sum, index and result valid, and loads the reset target.
`timescale 1ns / 1ps

module adc_moving_average_fan_duty #(
   parameter int WINDOW_LENGTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   amafd_req_if.sink   req_chan,
   amafd_rsp_if.source rsp_chan,
   input  logic        csr_write_enable,
   input  logic [14:0] csr_write_data
);
   import amafd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   amafd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   amafd_dp #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .st               (st)
   );

endmodule
